### rtl/ctl_pkg.sv
`timescale 1ns / 1ps

package ctl_pkg;

  localparam int LINE_BITS = 16;
  localparam int COL_BITS  = 12;

  localparam int LINE_W = 16;
  localparam int COL_W  = 12;
  localparam int LEN_W  = 12;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [3:0] {
    KIND_IDENT = 4'd0,
    KIND_OPEN  = 4'd1,
    KIND_CLOSE = 4'd2,
    KIND_COMMA = 4'd3,
    KIND_SEMI  = 4'd4,
    KIND_DOT   = 4'd5,
    KIND_NECK  = 4'd6,
    KIND_END   = 4'd7,
    KIND_ERROR = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [LEN_W-1:0]  length;
  } result_t;

  // one queue entry holds every word caused by one character
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

### rtl/ctl_front.sv
`timescale 1ns / 1ps

module ctl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_ch_i,
  output logic            push_o,
  output ctl_pkg::entry_t push_entry_o,
  input  logic            q_full_i
);
  import ctl_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_IDENT = 4'b0010,
    MODE_NECK  = 4'b0100,
    MODE_ERROR = 4'b1000
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [LINE_BITS-1:0] lc_q, lc_d;
  logic [COL_BITS-1:0]  cc_q, cc_d;
  logic [COL_BITS-1:0]  il_q, il_d;

  logic                 accept;
  logic [LINE_BITS-1:0] pos_line;
  logic [COL_BITS-1:0]  pos_col;
  logic [LINE_W-1:0]    out_line;
  logic [COL_W-1:0]     out_col;

  // decode of a character at token start
  logic  ic_emit;
  kind_e ic_kind;
  mode_e ic_mode;
  logic  ic_clear;
  logic  ic_ident;

  logic    emit0, emit1, do_clear;
  result_t res0, res1;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  always_comb begin
    lc_d = lc_q;
    cc_d = cc_q;
    if (in_ch_i == CH_NL) begin
      lc_d     = (lc_q != LINE_MAX) ? lc_q + 1'b1 : lc_q;
      cc_d     = COL_MAX;
      pos_line = (lc_d != '0) ? lc_d - 1'b1 : '0;
      pos_col  = cc_q + 1'b1;
    end else begin
      if (cc_q == COL_MAX) begin
        cc_d = '0;
      end else if (cc_q < COL_MAX - 1'b1) begin
        cc_d = cc_q + 1'b1;
      end
      pos_line = lc_q;
      pos_col  = cc_d;
    end
  end

  assign out_line = LINE_W'(pos_line);
  assign out_col  = COL_W'(pos_col);

  always_comb begin
    ic_emit  = 1'b0;
    ic_kind  = KIND_ERROR;
    ic_mode  = MODE_IDLE;
    ic_clear = 1'b0;
    ic_ident = 1'b0;
    priority if (in_ch_i == CH_COLON) begin
      ic_mode = MODE_NECK;
    end else if (is_letter(in_ch_i)) begin
      ic_mode  = MODE_IDENT;
      ic_ident = 1'b1;
    end else if (in_ch_i == CH_OPEN) begin
      ic_emit = 1'b1;
      ic_kind = KIND_OPEN;
    end else if (in_ch_i == CH_CLOSE) begin
      ic_emit = 1'b1;
      ic_kind = KIND_CLOSE;
    end else if (in_ch_i == CH_COMMA) begin
      ic_emit = 1'b1;
      ic_kind = KIND_COMMA;
    end else if (in_ch_i == CH_SEMI) begin
      ic_emit = 1'b1;
      ic_kind = KIND_SEMI;
    end else if (in_ch_i == CH_DOT) begin
      ic_emit = 1'b1;
      ic_kind = KIND_DOT;
    end else if (in_ch_i == CH_SPACE || in_ch_i == CH_NL) begin
      ic_emit = 1'b0;
    end else if (in_ch_i == CH_NUL) begin
      ic_emit  = 1'b1;
      ic_kind  = KIND_END;
      ic_clear = 1'b1;
    end else begin
      ic_emit = 1'b1;
      ic_kind = KIND_ERROR;
      ic_mode = MODE_ERROR;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    il_d     = il_q;
    emit0    = 1'b0;
    emit1    = 1'b0;
    do_clear = 1'b0;
    res0     = '{kind: KIND_ERROR, line: out_line, column: out_col, length: '0};
    res1     = '{kind: ic_kind, line: out_line, column: out_col, length: '0};
    unique case (mode_q)
      MODE_NECK: begin
        emit0 = 1'b1;
        if (in_ch_i == CH_DASH) begin
          res0.kind   = KIND_NECK;
          res0.column = COL_W'((pos_col != '0) ? pos_col - 1'b1 : '0);
          res0.length = LEN_W'(2);
          mode_d      = MODE_IDLE;
        end else if (in_ch_i == CH_NUL) begin
          do_clear = 1'b1;
        end else begin
          mode_d = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        do_clear = (in_ch_i == CH_NUL);
      end
      MODE_IDENT: begin
        if (is_letter(in_ch_i) || is_digit(in_ch_i)) begin
          if (il_q != COL_MAX) begin
            il_d = il_q + 1'b1;
          end
        end else begin
          // identifier ends here, then this character starts afresh
          emit0       = 1'b1;
          res0.kind   = KIND_IDENT;
          res0.column = COL_W'((pos_col >= il_q) ? pos_col - il_q : '0);
          res0.length = LEN_W'(il_q);
          emit1       = ic_emit;
          mode_d      = ic_mode;
          il_d        = ic_ident ? COL_BITS'(1) : '0;
          do_clear    = ic_clear;
        end
      end
      default: begin
        emit0     = ic_emit;
        res0.kind = ic_kind;
        mode_d    = ic_mode;
        if (ic_ident) begin
          il_d = COL_BITS'(1);
        end
        do_clear = ic_clear;
      end
    endcase
  end

  assign push_o            = accept && emit0;
  assign push_entry_o.two  = emit1;
  assign push_entry_o.r0   = res0;
  assign push_entry_o.r1   = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      lc_q   <= '0;
      cc_q   <= COL_MAX;
      il_q   <= '0;
    end else if (accept) begin
      if (do_clear) begin
        mode_q <= MODE_IDLE;
        lc_q   <= '0;
        cc_q   <= COL_MAX;
        il_q   <= '0;
      end else begin
        mode_q <= mode_d;
        lc_q   <= lc_d;
        cc_q   <= cc_d;
        il_q   <= il_d;
      end
    end
  end

endmodule

### rtl/ctl_queue.sv
`timescale 1ns / 1ps

module ctl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ctl_pkg::entry_t push_entry_i,
  output logic            full_o,
  output logic            valid_o,
  output ctl_pkg::entry_t head_o,
  input  logic            pop_i
);
  import ctl_pkg::*;

  entry_t               mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_BITS'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/ctl_back.sv
`timescale 1ns / 1ps

module ctl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  ctl_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ctl_pkg::result_t out_res_o,
  output logic             out_last_o
);
  import ctl_pkg::*;

  logic    valid_q, valid_d;
  logic    sel_q, sel_d;
  result_t res_q;
  logic    last_q;
  logic    load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        // second word of a pair goes out on the next load
        pop_o = !head_i.two || sel_q;
        sel_d = head_i.two && !sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      res_q  <= sel_q ? head_i.r1 : head_i.r0;
      last_q <= !head_i.two || sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

### rtl/clause_token_lexer_unit.sv
`timescale 1ns / 1ps
// channel   dir  tdata                          tuser  tlast
// s_axis    in   ch[7:0]                        -      -
// m_axis    out  line, column, length (40 bits) kind   last word of a character
//
// one character is taken per cycle while the result queue has room.
// a character causes zero, one or two words; the output register sends one
// word per cycle while the sink is ready, the two words of a pair in turn.
// the four-entry queue between lexer and output lets a stalled sink hold
// the output while characters keep coming until the queue fills.
// reset clears lexer state, queue and output valid; a nul does the same
// for the lexer state only.

module clause_token_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // ch[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // line[15:0], column[27:16], length[39:28]
  output logic [3:0]  m_axis_tuser_o,   // kind[3:0]
  output logic        m_axis_tlast_o
);
  import ctl_pkg::*;

  logic    push, full, q_valid, pop;
  entry_t  push_entry, head;
  result_t out_res;

  ctl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_ch_i     (s_axis_tdata_i),
    .push_o      (push),
    .push_entry_o(push_entry),
    .q_full_i    (full)
  );

  ctl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .valid_o     (q_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  ctl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (out_res),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_res.length, out_res.column, out_res.line};
  assign m_axis_tuser_o = out_res.kind;

endmodule

### sim/tb_clause_token_lexer_unit.sv
`timescale 1ns / 1ps

module tb_clause_token_lexer_unit;
  import ctl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CHARS = 950;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NECK  = 2'd2,
    MODE_ERROR = 2'd3
  } lex_mode_e;

  // idling phases
  typedef enum logic [1:0] {
    PH_FULL_RATE = 2'd0,
    PH_SRC_IDLE  = 2'd1,
    PH_SNK_STALL = 2'd2,
    PH_BOTH      = 2'd3
  } phase_e;

  typedef struct {
    logic [7:0] ch;
    phase_e     ph;
  } text_char_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] ln;
    logic [11:0] col;
    logic [11:0] len;
    logic        fin;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  clause_token_lexer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  text_char_t text_q[$];
  token_t     pending_tokens[$];
  token_t     step_tokens[$];
  phase_e     fill_ph = PH_FULL_RATE;
  phase_e     drv_ph = PH_FULL_RATE;
  text_char_t next_char;
  logic       go = 1'b0;
  logic       in_fire = 1'b0;
  int         err_cnt = 0;
  int         word_cnt = 0;
  int         quiet_cycles = 0;
  int         rand_base;

  // lexer shadow state
  lex_mode_e   mode;
  logic [15:0] line_cnt;
  logic [11:0] col_cnt;
  logic [11:0] prev_end_col;
  logic [11:0] id_len;

  task automatic clear_lexer();
    mode = MODE_IDLE;
    line_cnt = '0;
    col_cnt = COL_MAX;
    prev_end_col = '0;
    id_len = '0;
  endtask

  function automatic logic alpha_char(input logic [7:0] c);
    return c == CH_UNDER || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic add_token(input kind_e k, input logic [15:0] ln, input logic [11:0] col,
                           input logic [11:0] len);
    token_t t;
    t.kind = k;
    t.ln = ln;
    t.col = col;
    t.len = len;
    t.fin = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  // character seen while no token is open
  task automatic start_token(input logic [7:0] c, input logic [15:0] ln,
                             input logic [11:0] col);
    kind_e k;
    k = KIND_ERROR;
    if (c == CH_COLON) begin
      mode = MODE_NECK;
    end else if (alpha_char(c)) begin
      mode = MODE_IDENT;
      id_len = 12'd1;
    end else if (c == CH_SPACE || c == CH_NL) begin
      k = KIND_ERROR;
    end else if (c == CH_NUL) begin
      add_token(KIND_END, ln, col, '0);
      clear_lexer();
    end else begin
      case (c)
        CH_OPEN:  k = KIND_OPEN;
        CH_CLOSE: k = KIND_CLOSE;
        CH_COMMA: k = KIND_COMMA;
        CH_SEMI:  k = KIND_SEMI;
        CH_DOT:   k = KIND_DOT;
        default: begin
          k = KIND_ERROR;
          mode = MODE_ERROR;
        end
      endcase
      add_token(k, ln, col, '0);
    end
  endtask

  task automatic lex_char(input logic [7:0] c);
    logic [15:0] ln;
    logic [11:0] col;
    step_tokens.delete();
    // a newline sits at the end of the line it closes
    if (c == CH_NL) begin
      if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
      prev_end_col = col_cnt;
      col_cnt = COL_MAX;
      ln = (line_cnt > 0) ? line_cnt - 1'b1 : '0;
      col = prev_end_col + 1'b1;
    end else begin
      if (col_cnt == COL_MAX) col_cnt = '0;
      else if (col_cnt < COL_MAX - 1) col_cnt = col_cnt + 1'b1;
      ln = line_cnt;
      col = col_cnt;
    end
    case (mode)
      MODE_NECK: begin
        if (c == CH_DASH) begin
          add_token(KIND_NECK, ln, (col > 0) ? col - 1'b1 : '0, 12'd2);
          mode = MODE_IDLE;
        end else begin
          add_token(KIND_ERROR, ln, col, '0);
          if (c == CH_NUL) clear_lexer();
          else mode = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        if (c == CH_NUL) clear_lexer();
      end
      MODE_IDENT: begin
        if (alpha_char(c) || num_char(c)) begin
          if (id_len != COL_MAX) id_len = id_len + 1'b1;
        end else begin
          // identifier closes, then the same character starts over
          add_token(KIND_IDENT, ln, (col >= id_len) ? col - id_len : '0, id_len);
          mode = MODE_IDLE;
          id_len = '0;
          start_token(c, ln, col);
        end
      end
      default: start_token(c, ln, col);
    endcase
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].fin = 1'b1;
    foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch at word %0d: %s got %0d expected %0d", word_cnt, what, got, want);
  endtask

  task automatic check_word();
    token_t t;
    if (pending_tokens.size() == 0) begin
      report_mismatch("unexpected word, kind", 32'(m_axis_tuser_o), 32'(0));
    end else begin
      t = pending_tokens.pop_front();
      if (m_axis_tuser_o != t.kind)
        report_mismatch("kind", 32'(m_axis_tuser_o), 32'(t.kind));
      if (m_axis_tdata_o[15:0] != t.ln)
        report_mismatch("line", 32'(m_axis_tdata_o[15:0]), 32'(t.ln));
      if (m_axis_tdata_o[27:16] != t.col)
        report_mismatch("column", 32'(m_axis_tdata_o[27:16]), 32'(t.col));
      if (m_axis_tdata_o[39:28] != t.len)
        report_mismatch("length", 32'(m_axis_tdata_o[39:28]), 32'(t.len));
      if (m_axis_tlast_o != t.fin)
        report_mismatch("last", 32'(m_axis_tlast_o), 32'(t.fin));
    end
    word_cnt++;
  endtask

  function automatic int src_idle_pct(input phase_e ph);
    case (ph)
      PH_SRC_IDLE: return 81;
      PH_BOTH:     return 11;
      default:     return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct(input phase_e ph);
    case (ph)
      PH_SNK_STALL: return 81;
      PH_BOTH:      return 11;
      default:      return 0;
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (go) begin
      if (!s_valid || in_fire) begin
        if (text_q.size() > 0 && $urandom_range(99) >= src_idle_pct(text_q[0].ph)) begin
          next_char = text_q.pop_front();
          drv_ph = next_char.ph;
          s_valid <= 1'b1;
          s_data <= next_char.ch;
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= $urandom_range(99) >= snk_stall_pct(drv_ph);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= s_valid && s_axis_tready_o;
      if (s_valid && s_axis_tready_o) lex_char(s_data);
      if (m_axis_tvalid_o && m_ready) check_word();
    end
  end

  always @(posedge clk_i) begin
    if (go) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic put_ch(input logic [7:0] c);
    text_char_t t;
    t.ch = c;
    t.ph = fill_ph;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  function automatic logic [7:0] rand_first();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_tail();
    int r;
    r = $urandom_range(0, 62);
    if (r >= 52 && r < 62) return 8'("0" + r - 52);
    if (r < 52) return rand_first();
    return CH_UNDER;
  endfunction

  task automatic gen_ident();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    put_ch(rand_first());
    repeat (n) put_ch(rand_tail());
  endtask

  task automatic gen_gap();
    repeat ($urandom_range(0, 2)) put_ch(($urandom_range(0, 3) == 0) ? CH_NL : CH_SPACE);
  endtask

  task automatic gen_term();
    gen_ident();
    if ($urandom_range(0, 2) == 0) begin
      put_ch(CH_OPEN);
      gen_gap();
      gen_ident();
      repeat ($urandom_range(0, 2)) begin
        gen_gap();
        put_ch(CH_COMMA);
        gen_gap();
        gen_ident();
      end
      put_ch(CH_CLOSE);
    end
  endtask

  task automatic gen_clause();
    gen_term();
    gen_gap();
    if ($urandom_range(0, 1) == 0) begin
      put_ch(CH_COLON);
      put_ch(CH_DASH);
      gen_gap();
      gen_term();
      repeat ($urandom_range(0, 2)) begin
        gen_gap();
        put_ch(($urandom_range(0, 1) == 0) ? CH_COMMA : CH_SEMI);
        gen_gap();
        gen_term();
      end
      gen_gap();
    end
    put_ch(CH_DOT);
    gen_gap();
  endtask

  // bad input of several kinds, usually followed by end of text
  task automatic gen_noise();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: put_ch(8'($urandom_range(0, 255)));
      1: begin
        c = 8'($urandom_range(0, 255));
        put_ch(CH_COLON);
        put_ch((c == CH_DASH) ? "x" : c);
      end
      2: put_ch(8'("0" + $urandom_range(0, 9)));
      3: begin
        put_ch(CH_COLON);
        put_ch(CH_NUL);
      end
      default: repeat ($urandom_range(1, 4)) put_ch(8'($urandom_range(0, 255)));
    endcase
    gen_gap();
    if ($urandom_range(0, 4) != 0) put_ch(CH_NUL);
  endtask

  initial begin
    clear_lexer();

    // directed: tokens, ident closed by a symbol, neck, empty line, end cases
    fill_ph = PH_FULL_RATE;
    put_str("_z9(),;. :-\n\nQ");
    put_ch(CH_NUL);
    put_str(":x");
    put_ch(8'hFF);
    put_ch(CH_NUL);
    put_ch("7");
    put_ch(CH_NUL);
    put_ch(CH_COLON);
    put_ch(CH_NUL);
    put_ch(8'h80);
    put_ch(CH_NUL);
    put_ch(CH_NUL);

    rand_base = text_q.size();
    while (text_q.size() - rand_base < RANDOM_CHARS) begin
      fill_ph = phase_e'(((text_q.size() - rand_base) / 120) % 4);
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_clause();
      if ($urandom_range(0, 5) == 0) put_ch(CH_NUL);
    end
    put_ch(CH_NUL);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    go = 1'b1;

    while (text_q.size() > 0 || s_valid) @(posedge clk_i);
    while (pending_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && pending_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
